@@ rtl/ccr_pkg.sv @@
// Shared constants for the circle collision response block.
// No dependencies; used by the top level and its port checker.
package ccr_pkg;

    localparam int CW = 32;   // coordinate width, signed fixed point
    localparam int RW = 17;   // restitution register width, unsigned Q1.16

    // push mode codes shown on the result channel
    localparam logic [1:0] MODE_SWEEP = 2'd0;
    localparam logic [1:0] MODE_PUSH  = 2'd1;
    localparam logic [1:0] MODE_PASS  = 2'd2;

endpackage

@@ rtl/circle_collision_response_top.sv @@
// Swept circle collision response with restitution, fully pipelined.
// Depends on ccr_pkg for widths and the push mode codes.
//
// Takes one item per cycle while the output is not held. The pipeline holds
// two 34-step square-root pipelines (distance and speed, then the sweep root)
// and two 32-step divider pipelines (unit vectors); every other step is a
// single register stage. A held output freezes the whole pipeline; no item is
// lost or repeated. The user writes restitution through the configuration
// channel only while no item is in flight; the block does not enforce this.
module circle_collision_response_top
    import ccr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [CW-1:0] i_pos_x,
    input  logic signed [CW-1:0] i_pos_y,
    input  logic signed [CW-1:0] i_vel_x,
    input  logic signed [CW-1:0] i_vel_y,
    input  logic signed [CW-1:0] i_obstacle_x,
    input  logic signed [CW-1:0] i_obstacle_y,
    input  logic        [CW-2:0] i_radius_sum,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [CW-1:0] o_new_pos_x,
    output logic signed [CW-1:0] o_new_pos_y,
    output logic signed [CW-1:0] o_new_vel_x,
    output logic signed [CW-1:0] o_new_vel_y,
    output logic        [1:0]    o_push_mode,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic        [RW-1:0] i_restitution
);

    localparam int NSH = 30;          // unit vectors are Q2.30
    localparam int RSH = 16;          // restitution fraction bits
    localparam int NSQ = 34;          // root bits per square root
    localparam int NDV = 32;          // quotient bits per division
    localparam logic [17:0] REST_ONE   = 18'd65536;
    localparam logic [RW-1:0] REST_RST = 17'd65536;

    localparam int ST_SQ   = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_RA   = 3;
    localparam int ST_MODE = ST_RA + NSQ;
    localparam int ST_DA   = ST_MODE + 1;
    localparam int ST_UA   = ST_DA + NDV;
    localparam int ST_PA   = ST_UA + 1;
    localparam int ST_GV   = ST_PA + 1;
    localparam int ST_PT   = ST_GV + 1;
    localparam int ST_TERM = ST_PT + 1;
    localparam int ST_RB   = ST_TERM + 1;
    localparam int ST_S    = ST_RB + NSQ;
    localparam int ST_PS   = ST_S + 1;
    localparam int ST_CX   = ST_PS + 1;
    localparam int ST_CO   = ST_CX + 1;
    localparam int ST_DBI  = ST_CO + 1;
    localparam int ST_DB   = ST_DBI + 1;
    localparam int ST_UB   = ST_DB + NDV;
    localparam int ST_PV   = ST_UB + 1;
    localparam int ST_VN   = ST_PV + 1;
    localparam int ST_PK   = ST_VN + 1;
    localparam int ST_KVN  = ST_PK + 1;
    localparam int ST_PR   = ST_KVN + 1;
    localparam int ST_OUT  = ST_PR + 1;
    localparam int N       = ST_OUT + 1;

    typedef struct packed {
        logic [67:0] x;
        logic [37:0] rem;
        logic [35:0] root;
    } t_sq;

    typedef struct packed {
        logic [34:0] rem;
        logic [31:0] bits;
        logic [31:0] q;
        logic        neg;
        logic        zero;
        logic        sat;
    } t_dv;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic        [30:0] rs;
        logic signed [32:0] gx;
        logic signed [32:0] gy;
        logic        [1:0]  mode;
        logic        [32:0] gap;
        logic signed [33:0] pen;
        logic signed [73:0] p0;
        logic signed [73:0] p1;
        logic signed [73:0] p2;
        logic signed [73:0] p3;
        t_sq                sa;
        t_sq                sb;
        logic        [33:0] dd;
        t_dv                d1;
        t_dv                d2;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [33:0] nx;
        logic signed [33:0] ny;
        logic signed [35:0] gv;
        logic signed [36:0] s;
        logic signed [36:0] cx;
        logic signed [36:0] cy;
        logic signed [37:0] cox;
        logic signed [37:0] coy;
        logic signed [36:0] vn;
        logic signed [38:0] kvn;
        logic signed [31:0] opx;
        logic signed [31:0] opy;
        logic signed [31:0] ovx;
        logic signed [31:0] ovy;
    } t_item;

    // one root bit per step: bring down two radicand bits, try root*4+1
    function automatic t_sq f_sq_step(input t_sq a);
        t_sq         r;
        logic [37:0] acc;
        logic [37:0] trial;
        acc   = {a.rem[35:0], a.x[67:66]};
        trial = {a.root, 2'b01};
        r.x   = {a.x[65:0], 2'b00};
        if (acc >= trial) begin
            r.rem  = acc - trial;
            r.root = {a.root[34:0], 1'b1};
        end else begin
            r.rem  = acc;
            r.root = {a.root[34:0], 1'b0};
        end
        return r;
    endfunction

    // set up |a| * 2^30 / d; the top 32 dividend bits are already below d
    function automatic t_dv f_dv_init(input logic signed [37:0] a, input logic [33:0] d);
        t_dv         r;
        logic [37:0] m;
        m      = a[37] ? 38'(-a) : 38'(a);
        r.neg  = a[37];
        r.zero = (m == '0);
        r.sat  = (d == '0) || (m >= {2'b00, d, 2'b00}) || (m[37:34] != '0);
        r.rem  = {3'b000, m[33:2]};
        r.bits = {m[1:0], 30'd0};
        r.q    = '0;
        return r;
    endfunction

    function automatic t_dv f_dv_step(input t_dv a, input logic [33:0] d);
        t_dv         r;
        logic [34:0] acc;
        r      = a;
        acc    = {a.rem[33:0], a.bits[31]};
        r.bits = {a.bits[30:0], 1'b0};
        if (acc >= {1'b0, d}) begin
            r.rem = acc - {1'b0, d};
            r.q   = {a.q[30:0], 1'b1};
        end else begin
            r.rem = acc;
            r.q   = {a.q[30:0], 1'b0};
        end
        return r;
    endfunction

    // signed quotient, clamped to +-4.0 in Q2.30
    function automatic logic signed [33:0] f_dv_done(input t_dv a);
        logic [33:0] mag;
        if (a.zero) begin
            mag = '0;
        end else if (a.sat) begin
            mag = 34'd1 << NSH + 2;
        end else begin
            mag = {2'b00, a.q};
        end
        return a.neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [40:0] v);
        if (v[40:31] == '0 || v[40:31] == '1) begin
            return v[31:0];
        end
        return v[40] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    function automatic t_item f_stage(input int k, input t_item a, input logic [RW-1:0] rest);
        t_item              r;
        logic signed [73:0] t;
        logic        [33:0] dsel;
        logic        [17:0] kf;
        logic               sweep;
        r = a;
        if (k == ST_SQ) begin
            r.p0 = 74'(a.gx) * 74'(a.gx);
            r.p1 = 74'(a.gy) * 74'(a.gy);
            r.p2 = 74'(a.vx) * 74'(a.vx);
            r.p3 = 74'(a.vy) * 74'(a.vy);
        end else if (k == ST_SUM) begin
            r.sa   = '0;
            r.sb   = '0;
            r.sa.x = 68'(a.p0 + a.p1);
            r.sb.x = 68'(a.p2 + a.p3);
        end else if ((k >= ST_RA && k < ST_MODE) || (k >= ST_RB && k < ST_S)) begin
            r.sa = f_sq_step(a.sa);
            r.sb = f_sq_step(a.sb);
        end else if (k == ST_MODE) begin
            r.gap = a.sa.root[32:0];
            if (a.sb.root <= 36'd1) begin
                r.mode = (a.sa.root <= 36'd1) ? MODE_PASS : MODE_PUSH;
            end else begin
                r.mode = MODE_SWEEP;
            end
            sweep = (r.mode == MODE_SWEEP);
            r.pen = $signed({3'b000, a.rs}) - $signed({1'b0, a.sa.root[32:0]});
            dsel  = sweep ? {1'b0, a.sb.root[32:0]} : {1'b0, a.sa.root[32:0]};
            r.dd  = dsel;
            r.d1  = f_dv_init(sweep ? 38'(a.vx) : 38'(a.gx), dsel);
            r.d2  = f_dv_init(sweep ? 38'(a.vy) : 38'(a.gy), dsel);
        end else if ((k >= ST_DA && k < ST_UA) || (k >= ST_DB && k < ST_UB)) begin
            r.d1 = f_dv_step(a.d1, a.dd);
            r.d2 = f_dv_step(a.d2, a.dd);
        end else if (k == ST_UA) begin
            if (a.mode == MODE_SWEEP) begin
                r.dx = f_dv_done(a.d1);
                r.dy = f_dv_done(a.d2);
            end else begin
                r.nx = f_dv_done(a.d1);
                r.ny = f_dv_done(a.d2);
            end
        end else if (k == ST_PA) begin
            if (a.mode == MODE_SWEEP) begin
                r.p0 = 74'(a.gx) * 74'(a.dx);
                r.p1 = 74'(a.gy) * 74'(a.dy);
            end else begin
                r.p0 = 74'(a.pen) * 74'(a.nx);
                r.p1 = 74'(a.pen) * 74'(a.ny);
            end
        end else if (k == ST_GV) begin
            // sweep items use gv, pushed items their corrected centre
            t    = (a.p0 + a.p1) >>> NSH;
            r.gv = 36'(t);
            r.cx = 37'(a.px) + 37'(a.p0 >>> NSH);
            r.cy = 37'(a.py) + 37'(a.p1 >>> NSH);
        end else if (k == ST_PT) begin
            r.p0 = 74'(a.gv) * 74'(a.gv);
            r.p1 = 74'($signed({1'b0, a.rs})) * 74'($signed({1'b0, a.rs}));
            r.p2 = 74'($signed({1'b0, a.gap})) * 74'($signed({1'b0, a.gap}));
        end else if (k == ST_TERM) begin
            // the radicand is gv^2 + R^2 - gap^2; clamp a negative radicand
            t      = a.p0 + a.p1 - a.p2;
            r.sa   = '0;
            r.sb   = '0;
            r.sa.x = t[73] ? '0 : 68'(t);
        end else if (k == ST_S) begin
            r.s = 37'(a.gv) + 37'($signed({1'b0, a.sa.root[33:0]}));
        end else if (k == ST_PS) begin
            r.p0 = 74'(a.dx) * 74'(a.s);
            r.p1 = 74'(a.dy) * 74'(a.s);
        end else if (k == ST_CX) begin
            if (a.mode == MODE_SWEEP) begin
                r.cx = 37'(a.px) - 37'(a.p0 >>> NSH);
                r.cy = 37'(a.py) - 37'(a.p1 >>> NSH);
            end
        end else if (k == ST_CO) begin
            r.cox = 38'(a.cx) - 38'(a.ox);
            r.coy = 38'(a.cy) - 38'(a.oy);
        end else if (k == ST_DBI) begin
            r.dd = {3'b000, a.rs};
            r.d1 = f_dv_init(a.cox, {3'b000, a.rs});
            r.d2 = f_dv_init(a.coy, {3'b000, a.rs});
        end else if (k == ST_UB) begin
            if (a.mode == MODE_SWEEP) begin
                r.nx = f_dv_done(a.d1);
                r.ny = f_dv_done(a.d2);
            end
        end else if (k == ST_PV) begin
            r.p0 = 74'(a.vx) * 74'(a.nx);
            r.p1 = 74'(a.vy) * 74'(a.ny);
        end else if (k == ST_VN) begin
            r.vn = 37'((a.p0 + a.p1) >>> NSH);
        end else if (k == ST_PK) begin
            kf   = REST_ONE + 18'(rest);
            r.p0 = 74'(a.vn) * 74'($signed({1'b0, kf}));
        end else if (k == ST_KVN) begin
            r.kvn = 39'(a.p0 >>> RSH);
        end else if (k == ST_PR) begin
            r.p0 = 74'(a.kvn) * 74'(a.nx);
            r.p1 = 74'(a.kvn) * 74'(a.ny);
        end else if (k == ST_OUT) begin
            if (a.mode == MODE_PASS) begin
                r.opx = a.px;
                r.opy = a.py;
                r.ovx = a.vx;
                r.ovy = a.vy;
            end else begin
                r.opx = f_sat32(41'(a.cx));
                r.opy = f_sat32(41'(a.cy));
                r.ovx = f_sat32(41'(a.vx) - 41'(a.p0 >>> NSH));
                r.ovy = f_sat32(41'(a.vy) - 41'(a.p1 >>> NSH));
            end
        end
        return r;
    endfunction

    t_item         r_it [N];
    t_item         n_it [N];
    t_item         in_item;
    logic [N-1:0]  r_vld;
    logic [RW-1:0] r_restitution;
    logic          pipe_en;

    // the whole pipe holds while a finished item waits at the output
    assign pipe_en     = !r_vld[N-1] || i_ready;
    assign o_ready     = pipe_en;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        in_item    = '0;
        in_item.px = i_pos_x;
        in_item.py = i_pos_y;
        in_item.vx = i_vel_x;
        in_item.vy = i_vel_y;
        in_item.ox = i_obstacle_x;
        in_item.oy = i_obstacle_y;
        in_item.rs = i_radius_sum;
        in_item.gx = 33'(i_pos_x) - 33'(i_obstacle_x);
        in_item.gy = 33'(i_pos_y) - 33'(i_obstacle_y);
    end

    assign n_it[0] = in_item;

    for (genvar k = 1; k < N; k++) begin : g_stage
        assign n_it[k] = f_stage(k, r_it[k-1], r_restitution);
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_it <= n_it;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            r_restitution <= REST_RST;
        end else begin
            if (pipe_en) begin
                r_vld <= {r_vld[N-2:0], i_valid};
            end
            if (i_cfg_valid) begin
                r_restitution <= i_restitution;
            end
        end
    end

    assign o_valid     = r_vld[N-1];
    assign o_new_pos_x = r_it[N-1].opx;
    assign o_new_pos_y = r_it[N-1].opy;
    assign o_new_vel_x = r_it[N-1].ovx;
    assign o_new_vel_y = r_it[N-1].ovy;
    assign o_push_mode = r_it[N-1].mode;

endmodule

@@ rtl/ccr_checker.sv @@
// Port-level checks for the circle collision response top level.
// Depends on ccr_pkg; attached to the top level by the bind at the end.
module ccr_checker
    import ccr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic signed [CW-1:0] i_pos_x,
    input logic signed [CW-1:0] i_pos_y,
    input logic signed [CW-1:0] i_vel_x,
    input logic signed [CW-1:0] i_vel_y,
    input logic signed [CW-1:0] i_obstacle_x,
    input logic signed [CW-1:0] i_obstacle_y,
    input logic        [CW-2:0] i_radius_sum,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic signed [CW-1:0] o_new_pos_x,
    input logic signed [CW-1:0] o_new_pos_y,
    input logic signed [CW-1:0] o_new_vel_x,
    input logic signed [CW-1:0] o_new_vel_y,
    input logic        [1:0]    o_push_mode,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input logic        [RW-1:0] i_restitution
);

    // a stalled result item stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_new_pos_x) && $stable(o_new_pos_y)
            && $stable(o_new_vel_x) && $stable(o_new_vel_y) && $stable(o_push_mode))
        else $error("result item changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // an empty output slot always lets the next item in
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input refused with empty output");

    // a frozen pipeline takes no new item
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("item accepted while pipeline held");

endmodule

bind circle_collision_response_top ccr_checker u_ccr_checker (.*);
